FILE: hdl/ghs_pkg.sv
// Shared types, codes and constants for the gamepad hot-plug supervisor.
// Used by ghs_step and gamepad_hotplug_supervisor_top; depends on nothing.
package ghs_pkg;

   // Link state codes.
   localparam logic [1:0] LINK_OFF   = 2'd0;
   localparam logic [1:0] LINK_PLUG  = 2'd1;
   localparam logic [1:0] LINK_READY = 2'd2;

   // Register indexes on the configuration port.
   localparam logic [2:0] REG_MODE_ID_DIGITAL = 3'd0;
   localparam logic [2:0] REG_MODE_ID_ANALOG  = 3'd1;
   localparam logic [2:0] REG_LOSS_LIMIT      = 3'd2;
   localparam logic [2:0] REG_DEADZONE        = 3'd3;
   localparam logic [2:0] REG_STILL_FRAMES    = 3'd4;

   // Register reset values.
   localparam logic [7:0] MODE_ID_DIGITAL_RESET = 8'd65;
   localparam logic [7:0] MODE_ID_ANALOG_RESET  = 8'd115;
   localparam logic [3:0] LOSS_LIMIT_RESET      = 4'd3;
   localparam logic [6:0] DEADZONE_RESET        = 7'd8;
   localparam logic [3:0] STILL_FRAMES_RESET    = 4'd6;

   // State reset values and limits.
   localparam logic [3:0] STILL_COUNT_RESET = 4'd2;
   localparam logic [4:0] LOSS_COUNT_MAX    = 5'd31;
   localparam logic [4:0] LOSS_COUNT_BOUND  = 5'd16;
   localparam logic [8:0] AXIS_CENTRE       = 9'd128;

   typedef struct packed {
      logic [7:0] mode_id_digital;
      logic [7:0] mode_id_analog;
      logic [3:0] loss_limit;
      logic [6:0] deadzone;
      logic [3:0] still_frames;
   } ghs_cfg_type;

   typedef struct packed {
      logic [1:0] link_state;
      logic [4:0] loss_count;
      logic [3:0] still_count;
   } ghs_state_type;

   typedef struct packed {
      logic [7:0] probe_id;
      logic [7:0] reprobe_id;
      logic [7:0] axis_right_x;
      logic [7:0] axis_right_y;
      logic [7:0] axis_left_x;
      logic [7:0] axis_left_y;
   } ghs_item_type;

   typedef struct packed {
      logic       data_valid;
      logic [1:0] link_status;
      logic       do_reconfigure;
      logic       do_poll;
      logic       clear_buffer;
   } ghs_result_type;

endpackage

FILE: hdl/gamepad_hotplug_supervisor_top.sv
// Top level of the gamepad hot-plug supervisor: channels, registers, state.
// Depends on ghs_pkg and ghs_step.
//
// One request transfer carries one 10 ms tick of a polled gamepad link: the ID
// bytes of the tick's two probes and the four analog axis bytes. Each request
// gives exactly one response transfer with data valid, the link status after
// the tick and the actions to take (reconfigure, poll, clear the data buffer).
//
// A request is captured in an input register; a short compare-and-update step
// then moves it into the response register and updates the link state, the
// loss counter and the still-frame counter in the same cycle. Response valid
// rises once the item has passed through the input and response registers; one
// item is taken every cycle while the receiver does not stall, which the
// combinational state update allows.
//
// When the receiver stalls, the response register holds its item and the input
// register still accepts one more request; only when both are full is req_stall
// raised. Synchronous reset empties both registers, puts the link in off with a
// loss count of zero and a still count of two, and loads the register defaults.
// The csr_ port writes one of the five registers per cycle and should be used
// only while no transfer is in flight; indexes beyond the list are ignored.
module gamepad_hotplug_supervisor_top (
   input  logic       clock,
   input  logic       reset,
   // Configuration port.
   input  logic       csr_write_enable,
   input  logic [2:0] csr_index,
   input  logic [7:0] csr_write_data,
   // Request channel.
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_probe_id,
   input  logic [7:0] req_reprobe_id,
   input  logic [7:0] req_axis_right_x,
   input  logic [7:0] req_axis_right_y,
   input  logic [7:0] req_axis_left_x,
   input  logic [7:0] req_axis_left_y,
   // Response channel.
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_data_valid,
   output logic [1:0] rsp_link_status,
   output logic       rsp_do_reconfigure,
   output logic       rsp_do_poll,
   output logic       rsp_clear_buffer
);

   ghs_pkg::ghs_cfg_type    cfg_ff,    cfg_in;
   ghs_pkg::ghs_state_type  state_ff,  state_in;
   ghs_pkg::ghs_item_type   item_ff,   item_in;
   ghs_pkg::ghs_result_type result_ff, result_in;
   ghs_pkg::ghs_state_type  step_state;
   ghs_pkg::ghs_result_type step_result;
   logic                    item_valid_ff, item_valid_in;
   logic                    result_valid_ff, result_valid_in;
   logic                    advance;
   logic                    req_take;

   // The held item advances when the response register is empty or draining.
   assign advance   = item_valid_ff && (!result_valid_ff || !rsp_stall);
   assign req_stall = item_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   ghs_step u_step (
      .cfg        (cfg_ff),
      .state      (state_ff),
      .item       (item_ff),
      .state_next (step_state),
      .result     (step_result)
   );

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            ghs_pkg::REG_MODE_ID_DIGITAL: cfg_in.mode_id_digital = csr_write_data;
            ghs_pkg::REG_MODE_ID_ANALOG:  cfg_in.mode_id_analog  = csr_write_data;
            ghs_pkg::REG_LOSS_LIMIT:      cfg_in.loss_limit      = csr_write_data[3:0];
            ghs_pkg::REG_DEADZONE:        cfg_in.deadzone        = csr_write_data[6:0];
            ghs_pkg::REG_STILL_FRAMES:    cfg_in.still_frames    = csr_write_data[3:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      item_in.probe_id     = req_probe_id;
      item_in.reprobe_id   = req_reprobe_id;
      item_in.axis_right_x = req_axis_right_x;
      item_in.axis_right_y = req_axis_right_y;
      item_in.axis_left_x  = req_axis_left_x;
      item_in.axis_left_y  = req_axis_left_y;
      item_valid_in        = req_take || (item_valid_ff && !advance);
      state_in             = advance ? step_state : state_ff;
      result_in            = step_result;
      result_valid_in      = advance || (result_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode_id_digital <= ghs_pkg::MODE_ID_DIGITAL_RESET;
         cfg_ff.mode_id_analog  <= ghs_pkg::MODE_ID_ANALOG_RESET;
         cfg_ff.loss_limit      <= ghs_pkg::LOSS_LIMIT_RESET;
         cfg_ff.deadzone        <= ghs_pkg::DEADZONE_RESET;
         cfg_ff.still_frames    <= ghs_pkg::STILL_FRAMES_RESET;
         state_ff.link_state    <= ghs_pkg::LINK_OFF;
         state_ff.loss_count    <= '0;
         state_ff.still_count   <= ghs_pkg::STILL_COUNT_RESET;
         item_valid_ff          <= 1'b0;
         result_valid_ff        <= 1'b0;
      end else begin
         cfg_ff          <= cfg_in;
         state_ff        <= state_in;
         item_valid_ff   <= item_valid_in;
         result_valid_ff <= result_valid_in;
      end
   end

   // Payload registers load only on a transfer into them.
   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff <= item_in;
      end
      if (advance) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid          = result_valid_ff;
   assign rsp_data_valid     = result_ff.data_valid;
   assign rsp_link_status    = result_ff.link_status;
   assign rsp_do_reconfigure = result_ff.do_reconfigure;
   assign rsp_do_poll        = result_ff.do_poll;
   assign rsp_clear_buffer   = result_ff.clear_buffer;

   // A cleared buffer only ever goes with a link that has just dropped to off.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_clear_buffer) |-> (rsp_link_status == ghs_pkg::LINK_OFF))
      else $error("clear_buffer asserted while link is not off");

   // At most one action per tick.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $countones({rsp_do_reconfigure, rsp_do_poll, rsp_clear_buffer}) <= 1)
      else $error("more than one action in one response");

   // Valid stick data is only reported on a polled tick.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data_valid) |-> rsp_do_poll)
      else $error("data_valid without a poll");

   // An item that advances always shows up in the response register.
   assert property (@(posedge clock) disable iff (reset)
      advance |=> result_valid_ff)
      else $error("advanced item lost");

   // The loss counter stays within its bound.
   assert property (@(posedge clock) disable iff (reset)
      state_ff.loss_count <= ghs_pkg::LOSS_COUNT_BOUND)
      else $error("loss counter out of range");

endmodule

FILE: hdl/ghs_step.sv
// Single-tick update of the supervisor: next link state and result from one item.
// Purely combinational; depends on ghs_pkg.
module ghs_step (
   input  ghs_pkg::ghs_cfg_type    cfg,
   input  ghs_pkg::ghs_state_type  state,
   input  ghs_pkg::ghs_item_type   item,
   output ghs_pkg::ghs_state_type  state_next,
   output ghs_pkg::ghs_result_type result
);

   logic       probe_present;
   logic       reprobe_present;
   logic [4:0] loss_inc;
   logic       loss_drop;
   logic       all_still;

   // An axis is still when its offset from centre lies within +/- deadzone.
   function automatic logic axis_still(input logic [7:0] axis, input logic [6:0] dz);
      logic signed [8:0] offset;
      logic signed [8:0] limit;
      offset = $signed({1'b0, axis}) - $signed(ghs_pkg::AXIS_CENTRE);
      limit  = $signed({2'b00, dz});
      return (offset <= limit) && (offset >= -limit);
   endfunction

   assign probe_present   = (item.probe_id == cfg.mode_id_digital) ||
                            (item.probe_id == cfg.mode_id_analog);
   assign reprobe_present = (item.reprobe_id == cfg.mode_id_digital) ||
                            (item.reprobe_id == cfg.mode_id_analog);

   // The loss counter saturates; the drop test compares the incremented value.
   assign loss_inc  = (state.loss_count == ghs_pkg::LOSS_COUNT_MAX) ?
                      ghs_pkg::LOSS_COUNT_MAX : state.loss_count + 5'd1;
   assign loss_drop = loss_inc > {1'b0, cfg.loss_limit};

   assign all_still = axis_still(item.axis_right_x, cfg.deadzone) &&
                      axis_still(item.axis_right_y, cfg.deadzone) &&
                      axis_still(item.axis_left_x,  cfg.deadzone) &&
                      axis_still(item.axis_left_y,  cfg.deadzone);

   always_comb begin
      state_next = state;
      result     = '0;
      case (state.link_state)
         ghs_pkg::LINK_PLUG: begin
            if (probe_present) begin
               state_next.loss_count = '0;
            end else begin
               state_next.loss_count = loss_inc;
            end
            if (!probe_present && loss_drop) begin
               state_next.link_state = ghs_pkg::LINK_OFF;
            end else begin
               result.do_reconfigure = 1'b1;
               if (reprobe_present) begin
                  state_next.link_state  = ghs_pkg::LINK_READY;
                  state_next.loss_count  = '0;
                  state_next.still_count = cfg.still_frames;
               end
            end
         end
         ghs_pkg::LINK_READY: begin
            if (probe_present) begin
               state_next.loss_count = '0;
            end else begin
               state_next.loss_count = loss_inc;
            end
            if (!probe_present && loss_drop) begin
               state_next.link_state  = ghs_pkg::LINK_OFF;
               state_next.still_count = cfg.still_frames;
               result.clear_buffer    = 1'b1;
            end else begin
               result.do_poll = 1'b1;
               if (state.still_count != 4'd0) begin
                  if (all_still) begin
                     state_next.still_count = state.still_count - 4'd1;
                  end else begin
                     state_next.still_count = cfg.still_frames;
                  end
               end else begin
                  result.data_valid = 1'b1;
               end
            end
         end
         default: begin
            // Off, and the unused code, which behaves as off.
            state_next.link_state = ghs_pkg::LINK_OFF;
            if (probe_present) begin
               state_next.loss_count = '0;
               state_next.link_state = ghs_pkg::LINK_PLUG;
            end
         end
      endcase
      result.link_status = state_next.link_state;
   end

endmodule
